>>> hdl/sba_pkg.sv
package sba_pkg;

  localparam int ID_W = 16;
  localparam int LEN_W = 10;
  localparam int ENTRY_BYTES = 6;

  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_READ  = 2'd1,
    REQ_FREE  = 2'd2,
    REQ_SIZE  = 2'd3
  } req_type_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_ID_ZERO    = 3'd1,
    ST_NOT_FOUND  = 3'd2,
    ST_MISMATCH   = 3'd3,
    ST_BAD_LENGTH = 3'd4,
    ST_DIR_FULL   = 3'd5,
    ST_NO_SPACE   = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    RES_NONE,
    RES_LEN,
    RES_FOUND,
    RES_ALLOC
  } res_src_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOKUP,
    S_DECIDE,
    S_CHECK,
    S_SEARCH,
    S_RESOLVE
  } state_t;

  typedef struct packed {
    logic     capture;
    logic     scan_start;
    logic     scan_overlap;
    logic     top_init;
    logic     top_step;
    logic     grow;
    logic     use_free;
    logic     write_free;
    logic     write_alloc;
    logic     finish;
    status_t  code;
    res_src_t src;
  } cmd_t;

  typedef struct packed {
    logic id_zero;
    logic found;
    logic type_write;
    logic type_rw;
    logic type_free;
    logic len_match;
    logic len_bad;
    logic free_found;
    logic dir_full;
    logic low_short;
    logic top_fail;
    logic hit;
    logic ha_zero;
    logic scan_busy;
    logic res_free;
  } stat_t;

endpackage

>>> hdl/sba_req_if.sv
interface sba_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [15:0] block_id;
  logic [9:0] req_length;

  modport source(output valid, req_type, block_id, req_length, input ready);
  modport sink(input valid, req_type, block_id, req_length, output ready);
endinterface

>>> hdl/sba_rsp_if.sv
interface sba_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [9:0] block_address;
  logic [9:0] block_length;

  modport source(output valid, status, block_address, block_length, input ready);
  modport sink(input valid, status, block_address, block_length, output ready);
endinterface

>>> hdl/sba_datapath.sv
module sba_datapath #(
  parameter int STORE_BYTES = 1024,
  parameter int MAX_ENTRIES = 255,
  parameter int DIR_START = 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [1:0]    req_type,
  input  logic [15:0]   block_id,
  input  logic [9:0]    req_length,
  input  sba_pkg::cmd_t cmd,
  output sba_pkg::stat_t stat,
  output logic          res_valid,
  input  logic          res_ready,
  output logic [2:0]    status,
  output logic [9:0]    block_address,
  output logic [9:0]    block_length
);

  localparam int AW = $clog2(STORE_BYTES);
  localparam int W = (AW + 2 > 13) ? AW + 2 : 13;
  localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  typedef struct packed {
    logic [sba_pkg::ID_W-1:0]  id;
    logic [AW-1:0]             addr;
    logic [sba_pkg::LEN_W-1:0] len;
  } entry_t;

  entry_t mem [MAX_ENTRIES];
  entry_t rd_data;
  entry_t wr_data;
  logic [IW-1:0] wr_idx;
  logic mem_we;
  logic rd_en;

  logic [1:0] cur_type;
  logic [15:0] cur_id;
  logic [9:0] cur_len;
  logic [7:0] count;
  logic [7:0] idx;
  logic [7:0] rd_pos;
  logic rd_vld;
  logic scan_busy;
  logic mode_overlap;

  logic found;
  logic [7:0] found_slot;
  logic [AW-1:0] found_addr;
  logic [9:0] found_len;
  logic free_found;
  logic [7:0] free_slot;
  logic [W-1:0] lowest;
  logic [7:0] slot;
  logic [W-1:0] top;
  logic [W-1:0] cand;
  logic hit;
  logic [AW-1:0] hit_addr;

  logic [2:0] res_status;
  logic [9:0] res_addr;
  logic [9:0] res_len;

  logic [W-1:0] len_w;
  logic [W-1:0] floor_w;
  logic [W-1:0] grow_lim;
  logic [W-1:0] ea_w;
  logic [W-1:0] el_w;
  logic [W-1:0] faddr_w;
  logic [W-1:0] cand_next;

  assign len_w = W'(cur_len);
  assign floor_w = W'(DIR_START) + (W'(count) + W'(1)) * W'(sba_pkg::ENTRY_BYTES);
  assign grow_lim = W'(DIR_START) + (W'(count) + W'(2)) * W'(sba_pkg::ENTRY_BYTES);
  assign ea_w = W'(rd_data.addr);
  assign el_w = W'(rd_data.len);
  assign faddr_w = W'(found_addr);
  assign cand_next = top - len_w;

  assign rd_en = scan_busy && (idx < count);
  assign mem_we = cmd.write_free || cmd.grow || cmd.write_alloc;

  always_comb begin
    wr_idx = slot[IW-1:0];
    wr_data = '{id: cur_id, addr: cand[AW-1:0], len: cur_len};
    if (cmd.write_free) begin
      wr_idx = found_slot[IW-1:0];
      wr_data = '{id: '0, addr: found_addr, len: found_len};
    end else if (cmd.grow) begin
      wr_idx = count[IW-1:0];
      wr_data = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_idx] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[idx[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      scan_busy <= 1'b0;
      rd_vld <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      rd_vld <= rd_en;
      if (cmd.scan_start) begin
        scan_busy <= 1'b1;
      end else if (scan_busy && !rd_en && !rd_vld) begin
        scan_busy <= 1'b0;
      end
      if (cmd.grow) begin
        count <= count + 8'd1;
      end
      if (cmd.finish) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_pos <= idx;
    if (cmd.capture) begin
      cur_type <= req_type;
      cur_id <= block_id;
      cur_len <= req_length;
    end
    if (cmd.scan_start) begin
      idx <= '0;
      mode_overlap <= cmd.scan_overlap;
      if (cmd.scan_overlap) begin
        hit <= 1'b0;
        cand <= cand_next;
      end else begin
        found <= 1'b0;
        free_found <= 1'b0;
        lowest <= W'(STORE_BYTES);
      end
    end else if (rd_en) begin
      idx <= idx + 8'd1;
    end
    // keep the first match of each kind
    if (rd_vld) begin
      if (mode_overlap) begin
        if (!hit && cand < ea_w + el_w && ea_w < cand + len_w) begin
          hit <= 1'b1;
          hit_addr <= rd_data.addr;
        end
      end else begin
        if (!found && rd_data.id == cur_id) begin
          found <= 1'b1;
          found_slot <= rd_pos;
          found_addr <= rd_data.addr;
          found_len <= rd_data.len;
        end
        if (!free_found && rd_data.id == '0) begin
          free_found <= 1'b1;
          free_slot <= rd_pos;
        end
        if (ea_w < lowest) begin
          lowest <= ea_w;
        end
      end
    end
    if (cmd.use_free) begin
      slot <= free_slot;
    end else if (cmd.grow) begin
      slot <= count;
    end
    if (cmd.top_init) begin
      top <= W'(STORE_BYTES);
    end else if (cmd.top_step) begin
      top <= W'(hit_addr) - W'(1);
    end
    if (cmd.finish) begin
      res_status <= cmd.code;
      case (cmd.src)
        sba_pkg::RES_LEN: begin
          res_addr <= '0;
          res_len <= found_len;
        end
        sba_pkg::RES_FOUND: begin
          res_addr <= faddr_w[9:0];
          res_len <= found_len;
        end
        sba_pkg::RES_ALLOC: begin
          res_addr <= cand[9:0];
          res_len <= cur_len;
        end
        default: begin
          res_addr <= '0;
          res_len <= '0;
        end
      endcase
    end
  end

  always_comb begin
    stat.id_zero = (cur_id == '0);
    stat.found = found;
    stat.type_write = (cur_type == sba_pkg::REQ_WRITE);
    stat.type_rw = (cur_type == sba_pkg::REQ_WRITE) || (cur_type == sba_pkg::REQ_READ);
    stat.type_free = (cur_type == sba_pkg::REQ_FREE);
    stat.len_match = (cur_len == found_len);
    stat.len_bad = (cur_len == '0) || (len_w >= W'(STORE_BYTES));
    stat.free_found = free_found;
    stat.dir_full = (32'(count) >= MAX_ENTRIES);
    stat.low_short = (lowest < grow_lim);
    stat.top_fail = (top < len_w + floor_w);
    stat.hit = hit;
    stat.ha_zero = (hit_addr == '0);
    stat.scan_busy = scan_busy;
    stat.res_free = !res_valid || res_ready;
  end

  assign status = res_status;
  assign block_address = res_addr;
  assign block_length = res_len;

endmodule

>>> hdl/sba_ctrl.sv
module sba_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  sba_pkg::stat_t stat,
  output sba_pkg::cmd_t  cmd
);

  sba_pkg::state_t state;
  sba_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sba_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.code = sba_pkg::ST_OK;
    cmd.src = sba_pkg::RES_NONE;
    in_ready = (state == sba_pkg::S_IDLE);
    case (state)
      sba_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          cmd.scan_start = 1'b1;
          state_next = sba_pkg::S_LOOKUP;
        end
      end
      sba_pkg::S_LOOKUP: begin
        if (!stat.scan_busy) begin
          state_next = sba_pkg::S_DECIDE;
        end
      end
      sba_pkg::S_DECIDE: begin
        if (stat.id_zero) begin
          cmd.code = sba_pkg::ST_ID_ZERO;
          cmd.finish = stat.res_free;
        end else if (stat.found) begin
          if (stat.type_rw && !stat.len_match) begin
            cmd.code = sba_pkg::ST_MISMATCH;
            cmd.src = sba_pkg::RES_LEN;
          end else begin
            cmd.src = sba_pkg::RES_FOUND;
            cmd.write_free = stat.type_free && stat.res_free;
          end
          cmd.finish = stat.res_free;
        end else if (!stat.type_write) begin
          cmd.code = sba_pkg::ST_NOT_FOUND;
          cmd.finish = stat.res_free;
        end else if (stat.len_bad) begin
          cmd.code = sba_pkg::ST_BAD_LENGTH;
          cmd.finish = stat.res_free;
        end else if (stat.free_found) begin
          cmd.use_free = 1'b1;
          cmd.top_init = 1'b1;
          state_next = sba_pkg::S_CHECK;
        end else if (stat.dir_full) begin
          cmd.code = sba_pkg::ST_DIR_FULL;
          cmd.finish = stat.res_free;
        end else if (stat.low_short) begin
          cmd.code = sba_pkg::ST_NO_SPACE;
          cmd.finish = stat.res_free;
        end else begin
          // append a cleared entry above the directory
          cmd.grow = 1'b1;
          cmd.top_init = 1'b1;
          state_next = sba_pkg::S_CHECK;
        end
        if (cmd.finish) begin
          state_next = sba_pkg::S_IDLE;
        end
      end
      sba_pkg::S_CHECK: begin
        if (stat.top_fail) begin
          cmd.code = sba_pkg::ST_NO_SPACE;
          cmd.finish = stat.res_free;
          if (stat.res_free) begin
            state_next = sba_pkg::S_IDLE;
          end
        end else begin
          cmd.scan_start = 1'b1;
          cmd.scan_overlap = 1'b1;
          state_next = sba_pkg::S_SEARCH;
        end
      end
      sba_pkg::S_SEARCH: begin
        if (!stat.scan_busy) begin
          state_next = sba_pkg::S_RESOLVE;
        end
      end
      sba_pkg::S_RESOLVE: begin
        if (!stat.hit) begin
          cmd.src = sba_pkg::RES_ALLOC;
          cmd.write_alloc = stat.res_free;
          cmd.finish = stat.res_free;
          if (stat.res_free) begin
            state_next = sba_pkg::S_IDLE;
          end
        end else if (stat.ha_zero) begin
          cmd.code = sba_pkg::ST_NO_SPACE;
          cmd.finish = stat.res_free;
          if (stat.res_free) begin
            state_next = sba_pkg::S_IDLE;
          end
        end else begin
          // drop below the overlapping entry and try again
          cmd.top_step = 1'b1;
          state_next = sba_pkg::S_CHECK;
        end
      end
      default: begin
        state_next = sba_pkg::S_IDLE;
      end
    endcase
  end

endmodule

>>> hdl/storage_block_allocator_top.sv
// Storage block allocator: a directory of id, address and length entries
// for a byte store, with top-down first-fit placement.
// req channel carries req_type, block_id and req_length; rsp channel returns
// status, block_address and block_length, one response item per request.
// One request is worked at a time. The id lookup walks the n directory entries
// through the directory memory's single read port, so a request that does not
// allocate loads its response once the lookup ends, and the next request is
// taken once the controller is back in idle. An allocation then rescans the
// directory for every candidate range it tries, moving below each entry that
// overlaps, until a range is free or none is left.
// The response sits in an output register: the next request is accepted
// while it waits, and the block holds its following result until the
// receiver takes the pending one.
// Reset clears the entry count and the handshake state; the directory memory
// is not cleared, as entries are read only below the count.
module storage_block_allocator_top #(
  parameter int STORE_BYTES = 1024,
  parameter int MAX_ENTRIES = 255,
  parameter int DIR_START = 2
) (
  input logic  clk,
  input logic  rst,
  sba_req_if.sink   req,
  sba_rsp_if.source rsp
);

  sba_pkg::cmd_t cmd;
  sba_pkg::stat_t stat;

  sba_ctrl u_ctrl (
    .clk(clk),
    .rst(rst),
    .in_valid(req.valid),
    .in_ready(req.ready),
    .stat(stat),
    .cmd(cmd)
  );

  sba_datapath #(
    .STORE_BYTES(STORE_BYTES),
    .MAX_ENTRIES(MAX_ENTRIES),
    .DIR_START(DIR_START)
  ) u_dp (
    .clk(clk),
    .rst(rst),
    .req_type(req.req_type),
    .block_id(req.block_id),
    .req_length(req.req_length),
    .cmd(cmd),
    .stat(stat),
    .res_valid(rsp.valid),
    .res_ready(rsp.ready),
    .status(rsp.status),
    .block_address(rsp.block_address),
    .block_length(rsp.block_length)
  );

  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |-> !stat.scan_busy)
    else $error("request accepted during a directory scan");

  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> stat.res_free)
    else $error("result loaded over a pending response");

  a_grow_room: assert property (@(posedge clk) disable iff (rst)
    cmd.grow |-> (!stat.dir_full && !stat.low_short))
    else $error("directory grown without room");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.status != 3'd7))
    else $error("undefined status code");

endmodule

>>> bench/tb_storage_block_allocator_top.sv
`timescale 1ns / 1ps

module tb_storage_block_allocator_top;

  localparam int STORE = 1024;
  localparam int SLOTS = 255;
  localparam int DIR_BASE = 2;
  localparam int ID_POOL = 20;
  localparam int RANDOM_ITEMS = 1600;
  localparam longint CYCLE_LIMIT = 5000000;

  typedef struct {
    sba_pkg::req_type_t kind;
    logic [15:0]        id;
    logic [9:0]         len;
  } alloc_req_t;

  typedef struct {
    sba_pkg::status_t st;
    logic [9:0]       addr;
    logic [9:0]       len;
  } alloc_rsp_t;

  logic clk;
  logic rst;

  sba_req_if req ();
  sba_rsp_if rsp ();

  storage_block_allocator_top u_dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  alloc_req_t pending_reqs[$];
  alloc_rsp_t expected_rsps[$];
  int mismatches = 0;
  longint cycles = 0;
  int accepted = 0;
  bit long_hold = 0;

  // Directory shadow
  int dir_id[SLOTS];
  int dir_addr[SLOTS];
  int dir_len[SLOTS];
  int dir_count = 0;

  function automatic int find_entry(int id);
    for (int i = 0; i < dir_count; i++)
      if (dir_id[i] == id) return i;
    return -1;
  endfunction

  function automatic int first_clash(int a, int len);
    for (int i = 0; i < dir_count; i++)
      if (a < dir_addr[i] + dir_len[i] && dir_addr[i] < a + len) return i;
    return -1;
  endfunction

  function automatic sba_pkg::status_t place_block(int id, int len, output int slot);
    int lowest;
    int floor_b;
    int top_b;
    int hit;
    slot = -1;
    if (len == 0 || len >= STORE) return sba_pkg::ST_BAD_LENGTH;
    slot = find_entry(0);
    if (slot < 0) begin
      if (dir_count >= SLOTS) return sba_pkg::ST_DIR_FULL;
      lowest = STORE;
      for (int i = 0; i < dir_count; i++)
        if (dir_addr[i] < lowest) lowest = dir_addr[i];
      if (lowest < DIR_BASE + (dir_count + 2) * sba_pkg::ENTRY_BYTES)
        return sba_pkg::ST_NO_SPACE;
      slot = dir_count;
      dir_id[slot] = 0;
      dir_addr[slot] = 0;
      dir_len[slot] = 0;
      dir_count++;
    end
    floor_b = DIR_BASE + (dir_count + 1) * sba_pkg::ENTRY_BYTES;
    top_b = STORE;
    while (top_b >= len + floor_b) begin
      hit = first_clash(top_b - len, len);
      if (hit < 0) begin
        dir_id[slot] = id;
        dir_addr[slot] = top_b - len;
        dir_len[slot] = len;
        return sba_pkg::ST_OK;
      end
      if (dir_addr[hit] < 1) return sba_pkg::ST_NO_SPACE;
      top_b = dir_addr[hit] - 1;
    end
    return sba_pkg::ST_NO_SPACE;
  endfunction

  function automatic alloc_rsp_t predict_block(alloc_req_t r);
    alloc_rsp_t o;
    int slot;
    o.st = sba_pkg::ST_OK;
    o.addr = '0;
    o.len = '0;
    if (r.id == 0) begin
      o.st = sba_pkg::ST_ID_ZERO;
    end else begin
      slot = find_entry(int'(r.id));
      if (slot < 0) begin
        if (r.kind == sba_pkg::REQ_WRITE)
          o.st = place_block(int'(r.id), int'(r.len), slot);
        else
          o.st = sba_pkg::ST_NOT_FOUND;
      end
      if (o.st == sba_pkg::ST_OK) begin
        o.len = dir_len[slot][9:0];
        if ((r.kind == sba_pkg::REQ_WRITE || r.kind == sba_pkg::REQ_READ) &&
            r.len != o.len) begin
          o.st = sba_pkg::ST_MISMATCH;
        end else begin
          o.addr = dir_addr[slot][9:0];
          if (r.kind == sba_pkg::REQ_FREE) dir_id[slot] = 0;
        end
      end
    end
    return o;
  endfunction

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic add_req(sba_pkg::req_type_t k, int id, int len);
    alloc_req_t r;
    r.kind = k;
    r.id = id[15:0];
    r.len = len[9:0];
    pending_reqs.push_back(r);
  endtask

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    rst = 1;
    repeat (6) @(posedge clk);
    rst <= 0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("storage_block_allocator_top test failed");
      $finish;
    end
  end

  // Request driver
  int send_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (req.valid && req.ready) begin
        expected_rsps.push_back(predict_block(pending_reqs[0]));
        void'(pending_reqs.pop_front());
        accepted++;
        send_gap = pick_gap();
      end
      if (req.valid && !req.ready) begin
        // hold the offered item
      end else if (send_gap > 0) begin
        send_gap--;
        req.valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        req.valid <= 1'b1;
        req.req_type <= pending_reqs[0].kind;
        req.block_id <= pending_reqs[0].id;
        req.req_length <= pending_reqs[0].len;
      end else begin
        req.valid <= 1'b0;
      end
    end
  end

  // Response monitor
  int recv_gap = 0;
  always @(posedge clk) begin
    alloc_rsp_t e;
    if (rst) begin
      rsp.ready <= 1'b0;
      recv_gap = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (expected_rsps.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected response item status=%0d", rsp.status);
        end else begin
          e = expected_rsps.pop_front();
          if (rsp.status !== e.st || rsp.block_address !== e.addr ||
              rsp.block_length !== e.len) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp st=%0d addr=%0d len=%0d got st=%0d addr=%0d len=%0d",
                       e.st, e.addr, e.len, rsp.status, rsp.block_address, rsp.block_length);
          end
        end
      end
      if (long_hold) begin
        rsp.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= 1'b1;
        recv_gap = pick_gap();
      end
    end
  end

  // Long receiver stall while requests keep coming
  initial begin
    wait (accepted >= 400);
    @(posedge clk);
    long_hold = 1;
    repeat (500) @(posedge clk);
    long_hold = 0;
  end

  initial begin
    int pool_len[ID_POOL + 1];
    int id;
    int len;
    int p;
    sba_pkg::req_type_t k;

    req.valid = 1'b0;
    req.req_type = sba_pkg::REQ_WRITE;
    req.block_id = '0;
    req.req_length = '0;
    rsp.ready = 1'b0;

    add_req(sba_pkg::REQ_WRITE, 1, 0);
    add_req(sba_pkg::REQ_WRITE, 0, 5);
    add_req(sba_pkg::REQ_SIZE, 0, 0);
    add_req(sba_pkg::REQ_READ, 7, 4);
    add_req(sba_pkg::REQ_WRITE, 1, 16);
    add_req(sba_pkg::REQ_WRITE, 1, 16);
    add_req(sba_pkg::REQ_WRITE, 1, 17);
    add_req(sba_pkg::REQ_READ, 1, 16);
    add_req(sba_pkg::REQ_READ, 1, 3);
    add_req(sba_pkg::REQ_SIZE, 1, 1023);
    add_req(sba_pkg::REQ_FREE, 1, 0);
    add_req(sba_pkg::REQ_SIZE, 1, 0);
    add_req(sba_pkg::REQ_WRITE, 2, 1023);
    add_req(sba_pkg::REQ_WRITE, 3, 1000);
    add_req(sba_pkg::REQ_WRITE, 4, 900);
    add_req(sba_pkg::REQ_WRITE, 5, 1);
    add_req(sba_pkg::REQ_FREE, 4, 0);
    add_req(sba_pkg::REQ_WRITE, 6, 700);
    add_req(sba_pkg::REQ_WRITE, 16'hFFFF, 8);
    add_req(sba_pkg::REQ_READ, 16'hFFFF, 8);
    add_req(sba_pkg::REQ_FREE, 16'hFFFF, 0);
    add_req(sba_pkg::REQ_READ, 16'hFFFF, 8);
    add_req(sba_pkg::REQ_FREE, 7, 0);
    add_req(sba_pkg::REQ_FREE, 5, 0);
    add_req(sba_pkg::REQ_FREE, 6, 0);

    for (int i = 0; i <= ID_POOL; i++) pool_len[i] = $urandom_range(1, 48);
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      p = $urandom_range(0, 99);
      k = sba_pkg::req_type_t'($urandom_range(0, 3));
      id = $urandom_range(1, ID_POOL);
      if (p < 4) begin
        id = 0;
      end else if (p < 10) begin
        // wide ids stay out of writes so the directory does not keep growing
        id = $urandom_range(1, 65535);
        if (k == sba_pkg::REQ_WRITE) k = sba_pkg::REQ_SIZE;
      end
      if ($urandom_range(0, 19) == 0) begin
        p = $urandom_range(0, 9);
        pool_len[id % (ID_POOL + 1)] = (p < 7) ? $urandom_range(1, 64) :
                                       (p < 9) ? $urandom_range(65, 1023) : 0;
      end
      len = pool_len[id % (ID_POOL + 1)];
      if ($urandom_range(0, 9) == 0) len = $urandom_range(0, 1023);
      add_req(k, id, len);
    end

    wait (!rst);
    wait (pending_reqs.size() == 0 && expected_rsps.size() == 0);
    repeat (2000) @(posedge clk);
    if (mismatches == 0 && expected_rsps.size() == 0)
      $display("storage_block_allocator_top test passed");
    else
      $display("storage_block_allocator_top test failed");
    $finish;
  end

endmodule

>>> storage_block_allocator_top.f
hdl/sba_pkg.sv
hdl/sba_req_if.sv
hdl/sba_rsp_if.sv
hdl/sba_datapath.sv
hdl/sba_ctrl.sv
hdl/storage_block_allocator_top.sv
bench/tb_storage_block_allocator_top.sv
